// ===== hdl/i2cms_pkg.sv =====
package i2cms_pkg;

  // default transfer buffer depth in bytes
  localparam int BUFFER_DEPTH_DEF = 64;

  localparam int PTR_W = 7;
  localparam int LEN_W = 7;

  localparam logic [PTR_W-1:0] PTR_MAX = 7'd127;
  localparam logic [7:0] STATUS_MASK = 8'hFC;

  // masked bus status codes
  localparam logic [7:0] ST_START       = 8'h08;
  localparam logic [7:0] ST_REP_START   = 8'h10;
  localparam logic [7:0] ST_SLA_W_ACK   = 8'h18;
  localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
  localparam logic [7:0] ST_ARB_LOST    = 8'h38;
  localparam logic [7:0] ST_SLA_R_ACK   = 8'h40;
  localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
  localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_START = 2'd1,
    CMD_EVENT = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_START     = 3'd1,
    ACT_SEND      = 3'd2,
    ACT_STOP      = 3'd3,
    ACT_RX_ACK    = 3'd4,
    ACT_RX_NACK   = 3'd5,
    ACT_REP_START = 3'd6,
    ACT_RESET     = 3'd7
  } action_t;

  // buffer access request for one word
  typedef struct packed {
    logic wr;
    logic rd;
  } mem_ctl_t;

  // held result word, data bytes come from the buffer read register
  typedef struct packed {
    action_t action;
    logic    tx_sel;
    logic    rd_sel;
  } res_t;

  typedef struct packed {
    logic       done;
    logic       busy;
    logic       err_seen;
    logic [7:0] err_status;
  } flags_t;

endpackage

// ===== hdl/i2cms_buf.sv =====
module i2cms_buf #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic          rd_en,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wr_data,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/i2cms_seq.sv =====
module i2cms_seq #(
  parameter int BUFFER_DEPTH = 64,
  parameter int AW           = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  i2cms_pkg::cmd_t      command,
  input  logic [5:0]           index,
  input  logic [6:0]           length,
  input  logic [7:0]           bus_status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output i2cms_pkg::mem_ctl_t  mem_ctl,
  output logic [AW-1:0]        mem_addr,
  output i2cms_pkg::res_t      res,
  output i2cms_pkg::flags_t    flags
);

  import i2cms_pkg::*;

  // wide enough for any position and for the depth itself
  localparam int CW = (AW + 1 > PTR_W) ? AW + 1 : PTR_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);

  logic             accept;
  logic             out_valid_r, out_valid_nxt;
  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic [LEN_W-1:0] tl_r, tl_nxt;
  logic             done_r, done_nxt;
  logic             busy_r, busy_nxt;
  logic             err_r, err_nxt;
  logic [7:0]       err_rec_r, err_rec_nxt;
  res_t             res_r, res_nxt;
  mem_ctl_t         req;

  logic [7:0]       code;
  logic [PTR_W-1:0] ptr_base;
  logic [PTR_W-1:0] ptr_inc;
  logic [PTR_W-1:0] pos;
  logic [CW-1:0]    pos_ext;
  logic             pos_ok;
  logic [CW-1:0]    len_ext;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign code     = bus_status & STATUS_MASK;

  // start and repeated start rewind the pointer before sending
  assign ptr_base = (code == ST_START || code == ST_REP_START) ? '0 : ptr_r;
  assign ptr_inc  = (ptr_base == PTR_MAX) ? ptr_base : ptr_base + 7'd1;

  assign pos      = (command == CMD_EVENT) ? ptr_base : {1'b0, index};
  assign pos_ext  = CW'(pos);
  assign pos_ok   = pos_ext < DEPTH_C;
  assign mem_addr = pos_ext[AW-1:0];
  assign len_ext  = CW'(length);

  always_comb begin
    ptr_nxt     = ptr_r;
    tl_nxt      = tl_r;
    done_nxt    = done_r;
    busy_nxt    = busy_r;
    err_nxt     = err_r;
    err_rec_nxt = err_rec_r;
    res_nxt     = '{action: ACT_NONE, tx_sel: 1'b0, rd_sel: 1'b0};
    req         = '{wr: 1'b0, rd: 1'b0};
    case (command)
      CMD_WRITE: begin
        req.wr = pos_ok;
      end
      CMD_START: begin
        tl_nxt         = (len_ext > DEPTH_C) ? LEN_W'(BUFFER_DEPTH) : length;
        done_nxt       = 1'b0;
        busy_nxt       = 1'b1;
        res_nxt.action = ACT_START;
      end
      CMD_READ: begin
        req.rd         = pos_ok;
        res_nxt.rd_sel = pos_ok;
      end
      default: begin
        case (code) inside
          ST_START, ST_REP_START, ST_SLA_W_ACK, ST_DATA_W_ACK: begin
            ptr_nxt = ptr_base;
            if (ptr_base < tl_r) begin
              req.rd         = pos_ok;
              res_nxt.tx_sel = pos_ok;
              ptr_nxt        = ptr_inc;
              res_nxt.action = ACT_SEND;
            end else begin
              done_nxt       = 1'b1;
              busy_nxt       = 1'b0;
              res_nxt.action = ACT_STOP;
            end
          end
          ST_DATA_R_ACK: begin
            req.wr         = pos_ok;
            ptr_nxt        = ptr_inc;
            res_nxt.action = ({1'b0, ptr_inc} + 8'd1 < {1'b0, tl_r}) ? ACT_RX_ACK
                                                                    : ACT_RX_NACK;
          end
          ST_SLA_R_ACK: begin
            res_nxt.action = ({1'b0, ptr_r} + 8'd1 < {1'b0, tl_r}) ? ACT_RX_ACK
                                                                  : ACT_RX_NACK;
          end
          ST_DATA_R_NACK: begin
            req.wr         = pos_ok;
            done_nxt       = 1'b1;
            busy_nxt       = 1'b0;
            res_nxt.action = ACT_STOP;
          end
          ST_ARB_LOST: begin
            res_nxt.action = ACT_START;
          end
          default: begin
            err_rec_nxt    = bus_status;
            err_nxt        = 1'b1;
            busy_nxt       = 1'b0;
            res_nxt.action = ACT_RESET;
          end
        endcase
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ptr_r       <= '0;
      tl_r        <= '0;
      done_r      <= 1'b0;
      busy_r      <= 1'b0;
      err_r       <= 1'b0;
      err_rec_r   <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        ptr_r     <= ptr_nxt;
        tl_r      <= tl_nxt;
        done_r    <= done_nxt;
        busy_r    <= busy_nxt;
        err_r     <= err_nxt;
        err_rec_r <= err_rec_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign mem_ctl   = '{wr: accept && req.wr, rd: accept && req.rd};
  assign out_valid = out_valid_r;
  assign res       = res_r;
  assign flags     = '{done: done_r, busy: busy_r, err_seen: err_r, err_status: err_rec_r};

endmodule

// ===== hdl/i2c_master_transfer_sequencer_unit.sv =====
// byte-level i2c master sequencer with a transfer buffer
//
// input channel (in_valid / in_ready): one word is a command with its index,
// data, length and raw bus status. commands write or read a buffer byte,
// start a transfer, or hand over a bus status event from the twi engine
//
// result channel (out_valid / out_ready): one word per input word, carrying
// the next bus action, the byte to send, the buffer byte read back and the
// done, busy and error flags as they stand after that input word
//
// the word accepted at an edge is registered and shows on out_* right
// after it. throughput is one word per cycle while out_ready is high, set by the single buffer
// port that each word uses at most once and by the combinational decision path
//
// reset clears pointer, length, flags and the output valid; the buffer
// itself is not cleared and holds garbage until written
//
// when the receiver stalls the result register holds its word and in_ready
// drops, so nothing is lost; in_ready returns as soon as out_ready is high
module i2c_master_transfer_sequencer_unit #(
  parameter int BUFFER_DEPTH = i2cms_pkg::BUFFER_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_command,
  input  logic [5:0] in_index,
  input  logic [7:0] in_data,
  input  logic [6:0] in_length,
  input  logic [7:0] in_bus_status,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_action,
  output logic [7:0] out_tx_byte,
  output logic [7:0] out_read_data,
  output logic       out_transfer_ok,
  output logic       out_busy_res,
  output logic       out_error_seen,
  output logic [7:0] out_error_status
);

  import i2cms_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);

  mem_ctl_t      mem_ctl;
  logic [AW-1:0] mem_addr;
  logic [7:0]    buf_q;
  res_t          res;
  flags_t        flags;

  // decision logic, state registers and result register
  i2cms_seq #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .AW          (AW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (cmd_t'(in_command)),
    .index     (in_index),
    .length    (in_length),
    .bus_status(in_bus_status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .mem_ctl   (mem_ctl),
    .mem_addr  (mem_addr),
    .res       (res),
    .flags     (flags)
  );

  // transfer buffer, at most one access per word, read data registered
  i2cms_buf #(
    .DEPTH(BUFFER_DEPTH),
    .AW   (AW)
  ) u_buf (
    .clk    (clk),
    .wr_en  (mem_ctl.wr),
    .rd_en  (mem_ctl.rd),
    .addr   (mem_addr),
    .wr_data(in_data),
    .rd_data(buf_q)
  );

  // the buffer read register only moves on accept, so it holds under stall
  assign out_action       = res.action;
  assign out_tx_byte      = res.tx_sel ? buf_q : 8'd0;
  assign out_read_data    = res.rd_sel ? buf_q : 8'd0;
  assign out_transfer_ok  = flags.done;
  assign out_busy_res     = flags.busy;
  assign out_error_seen   = flags.err_seen;
  assign out_error_status = flags.err_status;

endmodule

// ===== tb/sv/i2c_master_transfer_sequencer_unit_tb.sv =====
module i2c_master_transfer_sequencer_unit_tb;
  import i2cms_pkg::*;

  localparam int DEPTH       = BUFFER_DEPTH_DEF;
  // cycles with no handshake on either side before the run is declared hung
  localparam int QUIET_LIMIT = 1000;
  localparam int WORD_TARGET = 1550;
  // from here on neither side idles
  localparam int CALM_FROM   = 1400;

  localparam logic [7:0] BUS_CODES [8] = '{ST_START, ST_REP_START, ST_SLA_W_ACK,
    ST_DATA_W_ACK, ST_ARB_LOST, ST_SLA_R_ACK, ST_DATA_R_ACK, ST_DATA_R_NACK};

  // one input word as the block sees it
  typedef struct packed {
    cmd_t       cmd;
    logic [5:0] index;
    logic [7:0] data;
    logic [6:0] length;
    logic [7:0] bus_status;
  } cmd_word_t;

  // one result word, same field order as the out_* ports
  typedef struct packed {
    action_t    action;
    logic [7:0] tx_byte;
    logic [7:0] read_data;
    logic       ok;
    logic       busy;
    logic       err_seen;
    logic [7:0] err_status;
  } reply_t;

  // mirror of the sequencer state plus the queue of replies still owed
  class twi_seq_tracker;
    logic [7:0]       mirror_mem [DEPTH];
    bit               written [DEPTH];
    logic [PTR_W-1:0] ptr;
    logic [LEN_W-1:0] xfer_len;
    logic             done;
    logic             busy;
    logic             err_flag;
    logic [7:0]       err_rec;
    reply_t           replies_due [$];
    int               mismatches;

    function new();
      ptr        = '0;
      xfer_len   = '0;
      done       = 1'b0;
      busy       = 1'b0;
      err_flag   = 1'b0;
      err_rec    = '0;
      mismatches = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function void store(int pos, logic [7:0] val);
      if (pos < DEPTH) begin
        mirror_mem[pos] = val;
        written[pos]    = 1'b1;
      end
    endfunction

    function logic [7:0] load(int pos);
      return (pos < DEPTH) ? mirror_mem[pos] : 8'h00;
    endfunction

    // pointer sticks at its maximum
    function void bump();
      if (ptr != PTR_MAX) ptr = ptr + PTR_W'(1);
    endfunction

    // buffer position this word would fetch while never written, else -1
    function int unwritten_load(cmd_word_t w);
      logic [7:0] code;
      int         pos;
      code = w.bus_status & STATUS_MASK;
      pos  = -1;
      if (w.cmd == CMD_READ) begin
        pos = int'(w.index);
      end else if (w.cmd == CMD_EVENT && (code == ST_START || code == ST_REP_START ||
                   code == ST_SLA_W_ACK || code == ST_DATA_W_ACK)) begin
        pos = (code == ST_START || code == ST_REP_START) ? 0 : int'(ptr);
        if (pos >= int'(xfer_len)) pos = -1;
      end
      if (pos >= 0 && pos < DEPTH && written[pos]) pos = -1;
      return pos;
    endfunction

    // advance the mirror by one accepted word and queue the reply it owes
    function void take_word(cmd_word_t w);
      reply_t     r;
      logic [7:0] code;
      r        = '0;
      r.action = ACT_NONE;
      code     = w.bus_status & STATUS_MASK;
      case (w.cmd)
        CMD_WRITE: store(int'(w.index), w.data);
        CMD_START: begin
          xfer_len = (int'(w.length) > DEPTH) ? LEN_W'(DEPTH) : w.length;
          done     = 1'b0;
          busy     = 1'b1;
          r.action = ACT_START;
        end
        CMD_READ: r.read_data = load(int'(w.index));
        default: begin
          case (code)
            ST_START, ST_REP_START, ST_SLA_W_ACK, ST_DATA_W_ACK: begin
              if (code == ST_START || code == ST_REP_START) ptr = '0;
              if (ptr < xfer_len) begin
                r.tx_byte = load(int'(ptr));
                bump();
                r.action = ACT_SEND;
              end else begin
                done     = 1'b1;
                busy     = 1'b0;
                r.action = ACT_STOP;
              end
            end
            ST_SLA_R_ACK, ST_DATA_R_ACK: begin
              if (code == ST_DATA_R_ACK) begin
                store(int'(ptr), w.data);
                bump();
              end
              // nack when the next byte is the last one
              r.action = (int'(ptr) + 1 < int'(xfer_len)) ? ACT_RX_ACK : ACT_RX_NACK;
            end
            ST_DATA_R_NACK: begin
              store(int'(ptr), w.data);
              done     = 1'b1;
              busy     = 1'b0;
              r.action = ACT_STOP;
            end
            ST_ARB_LOST: r.action = ACT_START;
            default: begin
              err_rec  = w.bus_status;
              err_flag = 1'b1;
              busy     = 1'b0;
              r.action = ACT_RESET;
            end
          endcase
        end
      endcase
      r.ok         = done;
      r.busy       = busy;
      r.err_seen   = err_flag;
      r.err_status = err_rec;
      replies_due.push_back(r);
    endfunction

    function void compare_reply(reply_t got);
      reply_t want;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: action %0d tx %h rd %h", got.action,
                   got.tx_byte, got.read_data);
        return;
      end
      want = replies_due.pop_front();
      if (got.action !== want.action || got.tx_byte !== want.tx_byte ||
          got.read_data !== want.read_data || got.ok !== want.ok ||
          got.busy !== want.busy || got.err_seen !== want.err_seen ||
          got.err_status !== want.err_status) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp: action %0d tx %h rd %h ok %b busy %b err %b st %h",
                   want.action, want.tx_byte, want.read_data, want.ok, want.busy,
                   want.err_seen, want.err_status);
          $display("         got: action %0d tx %h rd %h ok %b busy %b err %b st %h",
                   got.action, got.tx_byte, got.read_data, got.ok, got.busy,
                   got.err_seen, got.err_status);
        end
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_command;
  logic [5:0] in_index;
  logic [7:0] in_data;
  logic [6:0] in_length;
  logic [7:0] in_bus_status;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] out_action;
  logic [7:0] out_tx_byte;
  logic [7:0] out_read_data;
  logic       out_transfer_ok;
  logic       out_busy_res;
  logic       out_error_seen;
  logic [7:0] out_error_status;

  twi_seq_tracker tracker;

  int words_sent  = 0;
  bit sender_lazy = 1'b0;
  bit calm        = 1'b0;
  int stall_left  = 0;
  int stall_pct   = 0;
  int cycle_n     = 0;
  int quiet       = 0;

  i2c_master_transfer_sequencer_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_index         (in_index),
    .in_data          (in_data),
    .in_length        (in_length),
    .in_bus_status    (in_bus_status),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_action       (out_action),
    .out_tx_byte      (out_tx_byte),
    .out_read_data    (out_read_data),
    .out_transfer_ok  (out_transfer_ok),
    .out_busy_res     (out_busy_res),
    .out_error_seen   (out_error_seen),
    .out_error_status (out_error_status)
  );

  // period of two time units
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side: check every accepted word, stall in random bursts of random
  // density (zero density gives stall-free stretches)
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.compare_reply(reply_t'({out_action, out_tx_byte, out_read_data,
        out_transfer_ok, out_busy_res, out_error_seen, out_error_status}));
    cycle_n++;
    if (cycle_n % 64 == 0) stall_pct = 10 * $urandom_range(0, 3);
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // hang detector: no word moved on either channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= QUIET_LIMIT) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  function automatic cmd_word_t mk_word(cmd_t c, logic [5:0] idx, logic [7:0] dat,
                                        logic [6:0] len, logic [7:0] st);
    cmd_word_t w;
    w.cmd        = c;
    w.index      = idx;
    w.data       = dat;
    w.length     = len;
    w.bus_status = st;
    return w;
  endfunction

  // word with every field random except the command
  function automatic cmd_word_t any_word(cmd_t c);
    return mk_word(c, 6'($urandom), 8'($urandom), 7'($urandom), 8'($urandom));
  endfunction

  // mostly short transfers, now and then a long or oversized one
  function automatic int pick_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(9, 127) : $urandom_range(0, 8);
  endfunction

  // present one word and hold it until taken; valid stays high on return so
  // the caller must either present the next word or drop valid in this step
  task automatic push_word(input cmd_word_t w);
    if (!calm && sender_lazy && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= w.cmd;
    in_index      <= w.index;
    in_data       <= w.data;
    in_length     <= w.length;
    in_bus_status <= w.bus_status;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_word(w);
    words_sent++;
    if (words_sent >= CALM_FROM) calm = 1'b1;
  endtask

  // the buffer holds garbage until written, so any word that would fetch
  // an unwritten byte (read back or send) gets that byte written first
  task automatic issue(input cmd_word_t w);
    cmd_word_t fill;
    int        pos;
    pos = tracker.unwritten_load(w);
    if (pos >= 0) begin
      fill       = any_word(CMD_WRITE);
      fill.index = 6'(pos);
      push_word(fill);
    end
    push_word(w);
  endtask

  // bus status with random low bits, which the block masks away
  task automatic bus_event(input logic [7:0] code);
    cmd_word_t w;
    w            = any_word(CMD_EVENT);
    w.bus_status = code | 8'($urandom_range(0, 3));
    issue(w);
  endtask

  task automatic begin_transfer(input int len);
    cmd_word_t w;
    w        = any_word(CMD_START);
    w.length = 7'(len);
    issue(w);
  endtask

  task automatic put_byte(input int pos);
    cmd_word_t w;
    w       = any_word(CMD_WRITE);
    w.index = 6'(pos);
    issue(w);
  endtask

  // drop valid and hold off until every owed reply has come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.replies_due.size() != 0);
  endtask

  // master transmit: fill the buffer, start, then feed ack statuses until
  // the block stops; arbitration loss and stray statuses break in at random
  task automatic write_transfer();
    int len;
    int steps;
    len = pick_len();
    for (int i = 0; i < ((len > DEPTH) ? DEPTH : len); i++)
      if ($urandom_range(0, 3) != 0) put_byte(i);
    begin_transfer(len);
    bus_event(ST_START);
    steps = 0;
    while (tracker.busy && steps < 2 * DEPTH) begin
      case ($urandom_range(0, 19))
        0: begin
          bus_event(ST_ARB_LOST);
          bus_event(ST_REP_START);
        end
        1: bus_event(8'($urandom));
        default: bus_event((tracker.ptr == 1) ? ST_SLA_W_ACK : ST_DATA_W_ACK);
      endcase
      steps++;
    end
  endtask

  // master receive: address byte out, then data bytes in, last one nacked
  task automatic read_transfer();
    int len;
    len = pick_len();
    put_byte(0);
    begin_transfer(len);
    bus_event(ST_START);
    bus_event(ST_SLA_R_ACK);
    for (int i = 2; i < ((len > DEPTH) ? DEPTH : len); i++) bus_event(ST_DATA_R_ACK);
    if ($urandom_range(0, 9) == 0) bus_event(8'($urandom));
    bus_event(ST_DATA_R_NACK);
  endtask

  initial begin
    bit        long_done;
    cmd_word_t w;

    tracker       = new();
    long_done     = 1'b0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_command    <= CMD_WRITE;
    in_index      <= '0;
    in_data       <= '0;
    in_length     <= '0;
    in_bus_status <= '0;
    out_ready     <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // buffer ends, written and read back
    issue(mk_word(CMD_WRITE, 6'd0, 8'h00, 7'd0, 8'h00));
    issue(mk_word(CMD_WRITE, 6'd63, 8'hFF, 7'h7F, 8'hFF));
    issue(mk_word(CMD_READ, 6'd63, 8'h00, 7'd0, 8'h00));
    issue(mk_word(CMD_READ, 6'd0, 8'hFF, 7'h7F, 8'hFF));
    // events with no transfer running, zero length: stop, then nack, then start
    issue(mk_word(CMD_EVENT, 6'd0, 8'h00, 7'd0, ST_SLA_W_ACK));
    issue(mk_word(CMD_EVENT, 6'd0, 8'h00, 7'd0, ST_SLA_R_ACK));
    issue(mk_word(CMD_EVENT, 6'd0, 8'h00, 7'd0, ST_ARB_LOST));
    // unknown statuses, the full raw value is kept, then a nack status with low bits set
    issue(mk_word(CMD_EVENT, 6'd0, 8'h00, 7'd0, 8'h00));
    issue(mk_word(CMD_EVENT, 6'd0, 8'h00, 7'd0, 8'hFF));
    issue(mk_word(CMD_EVENT, 6'd0, 8'h3C, 7'd0, ST_DATA_R_NACK | 8'h03));
    // oversized length saturates, then zero length
    issue(mk_word(CMD_START, 6'd0, 8'h00, 7'h7F, 8'h00));
    issue(mk_word(CMD_START, 6'd0, 8'h00, 7'd0, 8'h00));
    // two-byte write transfer
    issue(mk_word(CMD_WRITE, 6'd1, 8'hA5, 7'd0, 8'h00));
    issue(mk_word(CMD_START, 6'd0, 8'h00, 7'd2, 8'h00));
    issue(mk_word(CMD_EVENT, 6'd0, 8'h00, 7'd0, ST_START));
    issue(mk_word(CMD_EVENT, 6'd0, 8'h00, 7'd0, ST_SLA_W_ACK | 8'h03));
    issue(mk_word(CMD_EVENT, 6'd0, 8'h00, 7'd0, ST_DATA_W_ACK));
    // three-byte read transfer opened with a repeated start
    issue(mk_word(CMD_START, 6'd0, 8'h00, 7'd3, 8'h00));
    issue(mk_word(CMD_EVENT, 6'd0, 8'h00, 7'd0, ST_REP_START | 8'h01));
    issue(mk_word(CMD_EVENT, 6'd0, 8'h00, 7'd0, ST_SLA_R_ACK));
    issue(mk_word(CMD_EVENT, 6'd0, 8'h5A, 7'd0, ST_DATA_R_ACK | 8'h03));
    issue(mk_word(CMD_EVENT, 6'd0, 8'hC3, 7'd0, ST_DATA_R_NACK));
    issue(mk_word(CMD_READ, 6'd2, 8'h00, 7'd0, 8'h00));
    issue(mk_word(CMD_EVENT, 6'd0, 8'h00, 7'd0, 8'h07));
    wait_drain();

    // random part: mostly well-formed transfers with random content
    while (words_sent < WORD_TARGET) begin
      sender_lazy = ($urandom_range(0, 2) != 0);
      if (!long_done && words_sent > 400) begin
        // long receive runs the pointer to its ceiling and past the buffer
        long_done = 1'b1;
        begin_transfer(pick_len());
        bus_event(ST_START);
        repeat (130) bus_event(ST_DATA_R_ACK);
        bus_event(ST_DATA_R_NACK);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: write_transfer();
          4, 5, 6:    read_transfer();
          default: begin
            repeat ($urandom_range(1, 6)) begin
              w = any_word(cmd_t'($urandom_range(0, 3)));
              if (w.cmd == CMD_EVENT && $urandom_range(0, 1) == 1)
                w.bus_status = BUS_CODES[$urandom_range(0, 7)] | 8'($urandom_range(0, 3));
              issue(w);
            end
          end
        endcase
      end
      if (!calm && $urandom_range(0, 14) == 0) wait_drain();
    end

    wait_drain();
    repeat (4) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.replies_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
